// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int ID_W    = 31;
    localparam int AGE_W   = 8;
    localparam int PHONE_W = 34;
    localparam int PRIO_W  = 2;
    localparam int REC_W   = ID_W + AGE_W + PHONE_W + PRIO_W;
    localparam int CNT_W   = 5;

    localparam logic [PHONE_W-1:0] PHONE_MIN = PHONE_W'(64'd1000000000);
    localparam logic [PHONE_W-1:0] PHONE_MAX = PHONE_W'(64'd9999999999);

    typedef enum logic [2:0] {
        MODE_ADMIT   = 3'd0,
        MODE_SERVE   = 3'd1,
        MODE_SEARCH  = 3'd2,
        MODE_COUNT   = 3'd3,
        MODE_LIST    = 3'd4,
        MODE_LISTPRI = 3'd5,
        MODE_HIST    = 3'd6,
        MODE_LASTSRV = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_PRIO  = 3'd3,
        ST_BAD_PHONE = 3'd4,
        ST_NOT_FOUND = 3'd5,
        ST_HIST_EMPTY = 3'd6
    } status_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [AGE_W-1:0]   age;
        logic [PHONE_W-1:0] phone;
        logic [PRIO_W-1:0]  prio;
    } rec_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,     // issue queue read
        S_SCAN_CHK,    // compare read data
        S_SHIFT_RD,    // read entry to move
        S_SHIFT_WR,    // write moved entry
        S_HIST_RD,
        S_HIST_CHK,
        S_OUT          // result held until taken
    } state_t;

endpackage

// ===== rtl/spq_ram.sv =====
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = spq_pkg::HISTORY_DEPTH_DEF,
    localparam int QA_W = $clog2(QUEUE_DEPTH),
    localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  in_mode,
    input  spq_pkg::rec_t               in_rec,
    input  logic [2:0]                  in_prio_full,
    input  logic [spq_pkg::ID_W-1:0]    in_qid,
    input  logic [2:0]                  in_qprio,
    output logic                        q_we,
    output logic [QA_W-1:0]             q_waddr,
    output spq_pkg::rec_t               q_wdata,
    output logic [QA_W-1:0]             q_raddr,
    input  spq_pkg::rec_t               q_rdata,
    output logic                        h_we,
    output logic [HA_W-1:0]             h_waddr,
    output spq_pkg::rec_t               h_wdata,
    output logic [HA_W-1:0]             h_raddr,
    input  spq_pkg::rec_t               h_rdata,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  out_status,
    output spq_pkg::rec_t               out_rec,
    output logic [spq_pkg::CNT_W-1:0]   out_wcnt,
    output logic [spq_pkg::CNT_W-1:0]   out_hcnt,
    output logic                        out_last,
    output logic                        busy
);
    import spq_pkg::*;

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int HC_W = $clog2(HISTORY_DEPTH + 1);

    state_t state_reg, state_next;
    mode_t  mode_reg, mode_next;
    rec_t   rec_reg, rec_next;
    logic [ID_W-1:0] qid_reg, qid_next;
    logic [2:0] qprio_reg, qprio_next;
    logic [QC_W-1:0] fill_reg, fill_next;
    logic [HC_W-1:0] hfill_reg, hfill_next;
    logic [HA_W-1:0] htop_reg, htop_next;
    logic [QC_W-1:0] idx_reg, idx_next;   // scan / shift index
    logic [QC_W-1:0] pos_reg, pos_next;   // insert point
    logic [HC_W-1:0] hidx_reg, hidx_next;
    rec_t   hold_reg, hold_next;          // record pending in shift
    logic   have_reg, have_next;          // a match held in hold_reg
    logic   after_reg, after_next;        // state after S_OUT
    logic [2:0] ost_reg, ost_next;
    rec_t   orec_reg, orec_next;
    logic   olast_reg, olast_next;

    // cycle-wide shared compare on the read record
    logic match;
    logic [QC_W-1:0] idx_inc;
    logic [HA_W-1:0] hslot;

    assign idx_inc = idx_reg + QC_W'(1);

    function automatic logic [HA_W-1:0] slot_back(logic [HA_W-1:0] top,
                                                   logic [HC_W-1:0] back);
        logic [HC_W+HA_W:0] s;
        begin
            s = (HC_W+HA_W+1)'(top) + (HC_W+HA_W+1)'(2*HISTORY_DEPTH - 1)
                - (HC_W+HA_W+1)'(back);
            // back < depth so s < 3*depth: two conditional subtracts
            if (s >= (HC_W+HA_W+1)'(2*HISTORY_DEPTH))
            begin
                s = s - (HC_W+HA_W+1)'(2*HISTORY_DEPTH);
            end
            else if (s >= (HC_W+HA_W+1)'(HISTORY_DEPTH))
            begin
                s = s - (HC_W+HA_W+1)'(HISTORY_DEPTH);
            end
            slot_back = HA_W'(s);
        end
    endfunction

    assign hslot = slot_back(htop_reg, hidx_reg);

    always_comb
    begin
        unique case (mode_reg)
            MODE_ADMIT:   match = (3'(q_rdata.prio) > 3'(rec_reg.prio));
            MODE_SEARCH:  match = (q_rdata.id == qid_reg);
            default:      match = (3'(q_rdata.prio) == qprio_reg);
        endcase
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_status = ost_reg;
    assign out_rec    = orec_reg;
    assign out_last   = olast_reg;
    assign out_wcnt   = CNT_W'(fill_reg);
    assign out_hcnt   = CNT_W'(hfill_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            hfill_reg <= '0;
            htop_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            hfill_reg <= hfill_next;
            htop_reg  <= htop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        rec_reg   <= rec_next;
        qid_reg   <= qid_next;
        qprio_reg <= qprio_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        hidx_reg  <= hidx_next;
        hold_reg  <= hold_next;
        have_reg  <= have_next;
        after_reg <= after_next;
        ost_reg   <= ost_next;
        orec_reg  <= orec_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        rec_next   = rec_reg;
        qid_next   = qid_reg;
        qprio_next = qprio_reg;
        fill_next  = fill_reg;
        hfill_next = hfill_reg;
        htop_next  = htop_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        hidx_next  = hidx_reg;
        hold_next  = hold_reg;
        have_next  = have_reg;
        after_next = after_reg;
        ost_next   = ost_reg;
        orec_next  = orec_reg;
        olast_next = olast_reg;
        q_we    = 1'b0;
        q_waddr = QA_W'(idx_reg);
        q_wdata = hold_reg;
        q_raddr = QA_W'(idx_reg);
        h_we    = 1'b0;
        h_waddr = htop_reg;
        h_wdata = q_rdata;
        h_raddr = hslot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next  = mode_t'(in_mode);
                    rec_next   = in_rec;
                    qid_next   = in_qid;
                    qprio_next = in_qprio;
                    idx_next   = '0;
                    hidx_next  = '0;
                    have_next  = 1'b0;
                    after_next = 1'b0;
                    ost_next   = ST_OK;
                    orec_next  = '0;
                    olast_next = 1'b1;
                    state_next = S_OUT;
                    unique case (mode_t'(in_mode))
                        MODE_ADMIT:
                        begin
                            if (in_rec.phone < PHONE_MIN || in_rec.phone > PHONE_MAX)
                                ost_next = ST_BAD_PHONE;
                            else if (in_prio_full < 3'd1 || in_prio_full > 3'd3)
                                ost_next = ST_BAD_PRIO;
                            else if (fill_reg >= QC_W'(QUEUE_DEPTH))
                                ost_next = ST_FULL;
                            else if (fill_reg == '0)
                            begin
                                pos_next   = '0;
                                idx_next   = '0;
                                state_next = S_SHIFT_WR;
                                hold_next  = in_rec;
                            end
                            else
                                state_next = S_SCAN_RD;
                        end
                        MODE_COUNT: ost_next = ST_OK;
                        MODE_HIST, MODE_LASTSRV:
                        begin
                            if (hfill_reg == '0)
                                ost_next = ST_HIST_EMPTY;
                            else
                                state_next = S_HIST_RD;
                        end
                        default:
                        begin
                            if (fill_reg == '0)
                                ost_next = ST_EMPTY;
                            else
                                state_next = S_SCAN_RD;
                        end
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                unique case (mode_reg)
                    MODE_ADMIT:
                    begin
                        if (match || idx_inc == fill_reg)
                        begin
                            // insert point found: shift tail up from the back
                            pos_next  = match ? idx_reg : idx_inc;
                            idx_next  = fill_reg;
                            hold_next = rec_reg;
                            state_next = (fill_reg == (match ? idx_reg : idx_inc))
                                ? S_SHIFT_WR : S_SHIFT_RD;
                            if (fill_reg == (match ? idx_reg : idx_inc))
                                idx_next = fill_reg;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_SERVE:
                    begin
                        // head record read; push to history, then shift down
                        h_we      = 1'b1;
                        htop_next = (htop_reg == HA_W'(HISTORY_DEPTH - 1))
                            ? '0 : htop_reg + HA_W'(1);
                        if (hfill_reg < HC_W'(HISTORY_DEPTH))
                            hfill_next = hfill_reg + HC_W'(1);
                        orec_next  = q_rdata;
                        ost_next   = ST_OK;
                        olast_next = 1'b1;
                        idx_next   = QC_W'(1);
                        state_next = (fill_reg == QC_W'(1)) ? S_OUT : S_SHIFT_RD;
                        if (fill_reg == QC_W'(1))
                            fill_next = '0;
                    end
                    MODE_SEARCH:
                    begin
                        if (match)
                        begin
                            orec_next  = q_rdata;
                            state_next = S_OUT;
                        end
                        else if (idx_inc == fill_reg)
                        begin
                            ost_next   = ST_NOT_FOUND;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = S_SCAN_RD;
                        end
                    end
                    MODE_LIST:
                    begin
                        orec_next  = q_rdata;
                        olast_next = (idx_inc == fill_reg);
                        after_next = (idx_inc != fill_reg);
                        idx_next   = idx_inc;
                        state_next = S_OUT;
                    end
                    default:
                    begin
                        // by priority: a match is held one step so the
                        // last flag is known when the next one turns up
                        if (match && have_reg)
                        begin
                            orec_next  = hold_reg;
                            olast_next = 1'b0;
                            after_next = 1'b1;
                            hold_next  = q_rdata;
                            state_next = S_OUT;
                        end
                        else if (match)
                        begin
                            hold_next = q_rdata;
                            have_next = 1'b1;
                        end
                        if (idx_inc == fill_reg)
                        begin
                            if (have_reg || match)
                            begin
                                if (!(match && have_reg))
                                begin
                                    orec_next  = match ? q_rdata : hold_reg;
                                    olast_next = 1'b1;
                                    after_next = 1'b0;
                                end
                                else
                                begin
                                    have_next = 1'b1;
                                end
                            end
                            else
                            begin
                                ost_next   = ST_NOT_FOUND;
                                after_next = 1'b0;
                            end
                            state_next = S_OUT;
                        end
                        else if (!(match && have_reg))
                        begin
                            state_next = S_SCAN_RD;
                        end
                        idx_next = idx_inc;
                    end
                endcase
            end
            S_SHIFT_RD:
            begin
                if (mode_reg == MODE_ADMIT)
                    q_raddr = QA_W'(idx_reg - QC_W'(1));
                state_next = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                q_we = 1'b1;
                if (mode_reg == MODE_ADMIT)
                begin
                    if (idx_reg == pos_reg)
                    begin
                        q_waddr    = QA_W'(pos_reg);
                        q_wdata    = rec_reg;
                        fill_next  = fill_reg + QC_W'(1);
                        orec_next  = rec_reg;
                        ost_next   = ST_OK;
                        olast_next = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        q_waddr    = QA_W'(idx_reg);
                        q_wdata    = q_rdata;
                        idx_next   = idx_reg - QC_W'(1);
                        state_next = (idx_reg - QC_W'(1) == pos_reg)
                            ? S_SHIFT_WR : S_SHIFT_RD;
                    end
                end
                else
                begin
                    q_waddr  = QA_W'(idx_reg - QC_W'(1));
                    q_wdata  = q_rdata;
                    idx_next = idx_inc;
                    if (idx_inc == fill_reg)
                    begin
                        fill_next  = fill_reg - QC_W'(1);
                        state_next = S_OUT;
                    end
                    else
                        state_next = S_SHIFT_RD;
                end
            end
            S_HIST_RD:
            begin
                state_next = S_HIST_CHK;
            end
            S_HIST_CHK:
            begin
                orec_next = h_rdata;
                ost_next  = ST_OK;
                if (mode_reg == MODE_LASTSRV)
                begin
                    olast_next = 1'b1;
                    after_next = 1'b0;
                end
                else
                begin
                    olast_next = (hidx_reg + HC_W'(1) == hfill_reg);
                    after_next = (hidx_reg + HC_W'(1) != hfill_reg);
                    hidx_next  = hidx_reg + HC_W'(1);
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (!after_reg)
                        state_next = S_IDLE;
                    else if (mode_reg == MODE_HIST)
                        state_next = S_HIST_RD;
                    else if (mode_reg == MODE_LISTPRI && have_reg &&
                             idx_reg == fill_reg)
                    begin
                        // last held match still to report
                        orec_next  = hold_reg;
                        olast_next = 1'b1;
                        after_next = 1'b0;
                    end
                    else
                        state_next = S_SCAN_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ===== rtl/stable_priority_queue_with_history_unit.sv =====
// Stable priority queue with service history.
// Input channel (in_valid/in_stall) carries one request: a mode plus admit
// fields and search keys. Output channel (out_valid/out_stall) returns one
// or more results per request; last marks the final one.
// Admit, serve, search and list modes walk the stored records one RAM
// access at a time through a single compare unit under a small sequencer.
// Admit scans for the insert point, then shifts the tail up; serve reads
// the head, pushes it to history and shifts the rest down; search reads
// and compares one record at a time; lists and history read one record
// per result; list by priority also reads records that do not match.
// Count and rejected admits skip the RAM walk. in_stall is high while a
// request is in progress; one request is handled at a time.
// Each result waits in the output register while out_stall is high; the
// sequencer holds until it is taken.
// Reset clears the queue and history fill counts and the history pointer;
// the record RAMs are not cleared since only written entries are read.
module stable_priority_queue_with_history_unit #(
    parameter int QUEUE_DEPTH   = spq_pkg::QUEUE_DEPTH_DEF,
    parameter int HISTORY_DEPTH = spq_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 mode,
    input  logic [spq_pkg::ID_W-1:0]    patient_id,
    input  logic [spq_pkg::AGE_W-1:0]   age,
    input  logic [spq_pkg::PHONE_W-1:0] phone,
    input  logic [2:0]                 priority_req,
    input  logic [spq_pkg::ID_W-1:0]    query_id,
    input  logic [2:0]                 query_priority,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [2:0]                 status,
    output logic [spq_pkg::ID_W-1:0]    rec_id,
    output logic [spq_pkg::AGE_W-1:0]   rec_age,
    output logic [spq_pkg::PHONE_W-1:0] rec_phone,
    output logic [spq_pkg::PRIO_W-1:0]  rec_priority,
    output logic [spq_pkg::CNT_W-1:0]   waiting_count,
    output logic [spq_pkg::CNT_W-1:0]   history_count,
    output logic                       last
);
    import spq_pkg::*;

    localparam int QA_W = $clog2(QUEUE_DEPTH);
    localparam int HA_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    rec_t in_rec, q_wdata, q_rdata, h_wdata, h_rdata, out_rec;
    logic q_we, h_we, busy;
    logic [QA_W-1:0] q_waddr, q_raddr;
    logic [HA_W-1:0] h_waddr, h_raddr;

    assign in_rec.id    = patient_id;
    assign in_rec.age   = age;
    assign in_rec.phone = phone;
    assign in_rec.prio  = priority_req[PRIO_W-1:0];

    // queue records in service order
    spq_ram #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_qram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // history ring, newest at top-1
    spq_ram #(.WIDTH(REC_W), .DEPTH(1 << HA_W)) u_hram (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    spq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH), .HISTORY_DEPTH(HISTORY_DEPTH)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_mode(mode),
        .in_rec(in_rec), .in_prio_full(priority_req), .in_qid(query_id),
        .in_qprio(query_priority),
        .q_we(q_we), .q_waddr(q_waddr), .q_wdata(q_wdata), .q_raddr(q_raddr),
        .q_rdata(q_rdata),
        .h_we(h_we), .h_waddr(h_waddr), .h_wdata(h_wdata), .h_raddr(h_raddr),
        .h_rdata(h_rdata),
        .out_valid(out_valid), .out_stall(out_stall), .out_status(status),
        .out_rec(out_rec), .out_wcnt(waiting_count), .out_hcnt(history_count),
        .out_last(last), .busy(busy)
    );

    assign rec_id       = out_rec.id;
    assign rec_age      = out_rec.age;
    assign rec_phone    = out_rec.phone;
    assign rec_priority = out_rec.prio;

    // no request taken while one is in progress
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("request accepted while busy");

    // a result only appears while a request is in progress
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> busy)
        else $error("result with no request in progress");

    // counts never exceed the depths
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (waiting_count <= CNT_W'(QUEUE_DEPTH)) &&
        (history_count <= CNT_W'(HISTORY_DEPTH)))
        else $error("fill count out of range");

    // an error status never carries a record
    a_err_norec: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (rec_id == '0 && rec_priority == '0))
        else $error("error result carries a record");
endmodule
